// ===== rtl/eul_pkg.sv =====
// Shared types, widths and constants for the Euler-angle to rotation-matrix block.
// Holds the CORDIC arctangent table and the sine/cosine pair type.
// No dependencies.
package eul_pkg;

	localparam int ANG_W            = 16;   // Q3.13 input angle
	localparam int SC_W             = 18;   // sine/cosine, Q.16
	localparam int X_W              = 34;   // CORDIC x/y datapath, Q.30
	localparam int Z_W              = 34;   // CORDIC angle, Q.30
	localparam int ANG_SHIFT        = 17;   // Q.13 -> Q.30
	localparam int RND_SHIFT        = 14;   // Q.30 -> Q.16
	localparam int ATAN_ENTRIES     = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int NLANE            = 3;    // yaw, pitch, roll
	localparam int NENT             = 9;    // matrix entries
	localparam int ENT_W            = 16;   // Q1.14 entry
	localparam int ENTRY_MAX        = 16384;

	localparam logic signed [Z_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
	localparam logic signed [Z_W-1:0] PI_Q30       = 34'sd3373259426;
	localparam logic signed [X_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [SC_W-1:0] s;
		logic signed [SC_W-1:0] c;
	} sincos_t;

	// atan(2^-i) in Q.30, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0:       v = 34'sd843314857;
			1:       v = 34'sd497837829;
			2:       v = 34'sd263043837;
			3:       v = 34'sd133525159;
			4:       v = 34'sd67021687;
			5:       v = 34'sd33543516;
			6:       v = 34'sd16775851;
			7:       v = 34'sd8388437;
			8:       v = 34'sd4194283;
			9:       v = 34'sd2097149;
			10:      v = 34'sd1048576;
			11:      v = 34'sd524288;
			12:      v = 34'sd262144;
			13:      v = 34'sd131072;
			14:      v = 34'sd65536;
			15:      v = 34'sd32768;
			16:      v = 34'sd16384;
			17:      v = 34'sd8192;
			18:      v = 34'sd4096;
			19:      v = 34'sd2048;
			20:      v = 34'sd1024;
			21:      v = 34'sd512;
			22:      v = 34'sd256;
			23:      v = 34'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/eul_cordic.sv =====
// Three-lane unrolled rotation-mode CORDIC: one register stage per iteration.
// Folds each angle into +/-pi/2 first, rounds x/y to Q.16 at the end.
// Depends on eul_pkg.
module eul_cordic #(
	parameter int CORDIC_STEPS = eul_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  logic                                        in_vld,
	input  logic [eul_pkg::NLANE-1:0][eul_pkg::ANG_W-1:0] ang,
	output logic                                        out_vld,
	output eul_pkg::sincos_t [eul_pkg::NLANE-1:0]       sc
);

	localparam int NSTEPS = (CORDIC_STEPS < eul_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : eul_pkg::ATAN_ENTRIES;
	localparam int XW = eul_pkg::X_W;
	localparam int ZW = eul_pkg::Z_W;
	localparam int NL = eul_pkg::NLANE;

	// index = stage; stage 0 is the fold register
	logic                 vld_s [NSTEPS+1];
	logic signed [XW-1:0] x_s   [NSTEPS+1][NL];
	logic signed [XW-1:0] y_s   [NSTEPS+1][NL];
	logic signed [ZW-1:0] z_s   [NSTEPS+1][NL];
	logic                 neg_s [NSTEPS+1][NL];
	logic                 vld_out_s;

	// fold stage
	logic signed [ZW-1:0] zw   [NL];
	logic signed [ZW-1:0] zf   [NL];
	logic                 zneg [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			zw[l] = ZW'($signed(ang[l])) <<< eul_pkg::ANG_SHIFT;
			if (zw[l] > eul_pkg::HALF_PI_Q30) begin
				zf[l]   = zw[l] - eul_pkg::PI_Q30;
				zneg[l] = 1'b1;
			end else if (zw[l] < -eul_pkg::HALF_PI_Q30) begin
				zf[l]   = zw[l] + eul_pkg::PI_Q30;
				zneg[l] = 1'b1;
			end else begin
				zf[l]   = zw[l];
				zneg[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				x_s[0][l]   <= eul_pkg::INV_GAIN_Q30;
				y_s[0][l]   <= '0;
				z_s[0][l]   <= zf[l];
				neg_s[0][l] <= zneg[l];
			end
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < NSTEPS; k++) begin : g_step
		localparam logic signed [ZW-1:0] ATAN_K = eul_pkg::atan_q30(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < NL; l++) begin
					neg_s[k+1][l] <= neg_s[k][l];
					if (!z_s[k][l][ZW-1]) begin
						x_s[k+1][l] <= x_s[k][l] - (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] + (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] - ATAN_K;
					end else begin
						x_s[k+1][l] <= x_s[k][l] + (y_s[k][l] >>> k);
						y_s[k+1][l] <= y_s[k][l] - (x_s[k][l] >>> k);
						z_s[k+1][l] <= z_s[k][l] + ATAN_K;
					end
				end
			end
		end
	end

	// round half up to Q.16, undo the fold by negation
	logic signed [XW-1:0]            xr [NL];
	logic signed [XW-1:0]            yr [NL];
	logic signed [eul_pkg::SC_W-1:0] cq [NL];
	logic signed [eul_pkg::SC_W-1:0] sq [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			xr[l] = (x_s[NSTEPS][l] + XW'(8192)) >>> eul_pkg::RND_SHIFT;
			yr[l] = (y_s[NSTEPS][l] + XW'(8192)) >>> eul_pkg::RND_SHIFT;
			cq[l] = neg_s[NSTEPS][l] ? -xr[l][eul_pkg::SC_W-1:0] : xr[l][eul_pkg::SC_W-1:0];
			sq[l] = neg_s[NSTEPS][l] ? -yr[l][eul_pkg::SC_W-1:0] : yr[l][eul_pkg::SC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else if (en) begin
			vld_out_s <= vld_s[NSTEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				sc[l].c <= cq[l];
				sc[l].s <= sq[l];
			end
		end
	end

	assign out_vld = vld_out_s;

endmodule

// ===== rtl/eul_matrix.sv =====
// Four-stage product pipeline: pair products, triple products, Q.48 sums,
// then round half up to Q1.14 with saturation. Depends on eul_pkg.
module eul_matrix (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             en,
	input  logic                                             in_vld,
	input  eul_pkg::sincos_t [eul_pkg::NLANE-1:0]            sc,
	output logic                                             out_vld,
	output logic [eul_pkg::NENT-1:0][eul_pkg::ENT_W-1:0]     r
);

	localparam int SW   = eul_pkg::SC_W;
	localparam int PW   = 2 * SW;      // pair product, Q.32
	localparam int TW   = 3 * SW;      // triple product, Q.48
	localparam int AW   = 56;          // Q.48 accumulator
	localparam int QW   = AW - 34;     // after rounding shift
	localparam int NE   = eul_pkg::NENT;

	// lane 0 yaw (c3,s3), lane 1 pitch (c2,s2), lane 2 roll (c1,s1)
	logic signed [SW-1:0] c1, s1, c2, s2, c3, s3;
	assign c3 = sc[0].c;
	assign s3 = sc[0].s;
	assign c2 = sc[1].c;
	assign s2 = sc[1].s;
	assign c1 = sc[2].c;
	assign s1 = sc[2].s;

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// stage 1: pair products
	logic signed [PW-1:0] c2c3_s1, c1s3_s1, s1s3_s1, c2s3_s1, c1c3_s1;
	logic signed [PW-1:0] c3s1_s1, c2s1_s1, c1c2_s1, s1s2_s1, c1s2_s1;
	logic signed [SW-1:0] s2_s1, s3_s1;

	// stage 2: triple products, pair products carried
	logic signed [TW-1:0] t01_s2, t02_s2, t11_s2, t12_s2;
	logic signed [PW-1:0] c2c3_s2, c1s3_s2, s1s3_s2, c2s3_s2, c1c3_s2;
	logic signed [PW-1:0] c3s1_s2, c2s1_s2, c1c2_s2;
	logic signed [SW-1:0] s2_s2;

	// stage 3: Q.48 sums
	logic signed [AW-1:0] acc_s3 [NE];

	// stage 4: saturated entries
	logic [eul_pkg::ENT_W-1:0] ent_s4 [NE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c2c3_s1 <= c2 * c3;
			c1s3_s1 <= c1 * s3;
			s1s3_s1 <= s1 * s3;
			c2s3_s1 <= c2 * s3;
			c1c3_s1 <= c1 * c3;
			c3s1_s1 <= c3 * s1;
			c2s1_s1 <= c2 * s1;
			c1c2_s1 <= c1 * c2;
			s1s2_s1 <= s1 * s2;
			c1s2_s1 <= c1 * s2;
			s2_s1   <= s2;
			s3_s1   <= s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t01_s2  <= c3s1_s1 * s2_s1;
			t02_s2  <= c1c3_s1 * s2_s1;
			t11_s2  <= s1s2_s1 * s3_s1;
			t12_s2  <= c1s2_s1 * s3_s1;
			c2c3_s2 <= c2c3_s1;
			c1s3_s2 <= c1s3_s1;
			s1s3_s2 <= s1s3_s1;
			c2s3_s2 <= c2s3_s1;
			c1c3_s2 <= c1c3_s1;
			c3s1_s2 <= c3s1_s1;
			c2s1_s2 <= c2s1_s1;
			c1c2_s2 <= c1c2_s1;
			s2_s2   <= s2_s1;
		end
	end

	// pair product to Q.48
	function automatic logic signed [AW-1:0] up16(input logic signed [PW-1:0] p);
		return AW'(p) <<< 16;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s3[0] <= up16(c2c3_s2);
			acc_s3[1] <= AW'(t01_s2) - up16(c1s3_s2);
			acc_s3[2] <= up16(s1s3_s2) + AW'(t02_s2);
			acc_s3[3] <= up16(c2s3_s2);
			acc_s3[4] <= up16(c1c3_s2) + AW'(t11_s2);
			acc_s3[5] <= AW'(t12_s2) - up16(c3s1_s2);
			acc_s3[6] <= -(AW'(s2_s2) <<< 32);
			acc_s3[7] <= up16(c2s1_s2);
			acc_s3[8] <= up16(c1c2_s2);
		end
	end

	logic signed [AW-1:0] rnd [NE];
	logic signed [QW-1:0] q   [NE];
	logic [eul_pkg::ENT_W-1:0] sat [NE];

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			rnd[e] = (acc_s3[e] + (AW'(1) <<< 33)) >>> 34;
			q[e]   = rnd[e][QW-1:0];
			if (q[e] > QW'(eul_pkg::ENTRY_MAX)) begin
				sat[e] = eul_pkg::ENT_W'(eul_pkg::ENTRY_MAX);
			end else if (q[e] < -QW'(eul_pkg::ENTRY_MAX)) begin
				sat[e] = -eul_pkg::ENT_W'(eul_pkg::ENTRY_MAX);
			end else begin
				sat[e] = q[e][eul_pkg::ENT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < NE; e++) begin
				ent_s4[e] <= sat[e];
			end
		end
	end

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			r[e] = ent_s4[e];
		end
	end

	assign out_vld = vld_s4;

endmodule

// ===== rtl/euler_to_rotation_matrix_top.sv =====
// Top level: Euler angles (yaw, pitch, roll) to Z-Y'-X'' rotation matrix.
// Instantiates eul_cordic and eul_matrix; depends on eul_pkg.
//
// Usage:
//  - Input channel s_*: one transaction carries yaw, pitch and roll, each a
//    signed Q3.13 angle in radians. Any 16-bit pattern is legal; angles past
//    +/-pi/2 are folded by one half-turn before the CORDIC.
//  - Output channel m_*: one transaction per input transaction, in order,
//    carrying the nine matrix entries R = Rz(yaw) Ry(pitch) Rx(roll) in
//    signed Q1.14, rounded half up and saturated to +/-16384.
//  - Throughput: one transaction per cycle while m_tready does not stall the output.
//  - Pipeline: an accepted transaction reaches m_tvalid through
//    min(CORDIC_STEPS, 24) + 6 registers: one per micro-rotation, plus a
//    fold stage, a rounding stage and the four-stage multiply/round
//    pipeline.
//  - Stall: the whole pipeline advances on one enable, high whenever the
//    output register is empty or being taken. While the receiver holds
//    m_tready low with m_tvalid high, every stage and s_tready freeze, so
//    nothing is dropped or repeated.
//  - Reset: arst_n clears all valid bits at once; the pipeline is empty and
//    ready as soon as reset is released. Data registers have no reset.
module euler_to_rotation_matrix_top #(
	parameter int CORDIC_STEPS = eul_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // yaw [15:0], pitch [31:16], roll [47:32]
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // r00, r01, r02, r10, r11, r12, r20, r21, r22,
	                                // 16 bits each from bit 0 up
);

	// global pipeline enable: output register free or draining
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic [eul_pkg::NLANE-1:0][eul_pkg::ANG_W-1:0] ang;
	assign ang[0] = s_tdata[15:0];
	assign ang[1] = s_tdata[31:16];
	assign ang[2] = s_tdata[47:32];

	logic                                  sc_vld;
	eul_pkg::sincos_t [eul_pkg::NLANE-1:0] sc;

	eul_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.ang     (ang),
		.out_vld (sc_vld),
		.sc      (sc)
	);

	logic [eul_pkg::NENT-1:0][eul_pkg::ENT_W-1:0] ent;

	eul_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sc_vld),
		.sc      (sc),
		.out_vld (m_tvalid),
		.r       (ent)
	);

	assign m_tdata = ent;

	// ---- checks ----
	logic ent_ok;
	logic sc_ok;

	always_comb begin
		ent_ok = 1'b1;
		for (int e = 0; e < eul_pkg::NENT; e++) begin
			if ($signed(ent[e]) > 16'sd16384 || $signed(ent[e]) < -16'sd16384) begin
				ent_ok = 1'b0;
			end
		end
		sc_ok = 1'b1;
		for (int l = 0; l < eul_pkg::NLANE; l++) begin
			if (sc[l].s > 18'sd66000 || sc[l].s < -18'sd66000 ||
			    sc[l].c > 18'sd66000 || sc[l].c < -18'sd66000) begin
				sc_ok = 1'b0;
			end
		end
	end

	// saturation keeps every entry inside +/-1.0
	a_ent_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ent_ok)
		else $error("matrix entry outside +/-16384");

	// CORDIC results stay near unit magnitude
	a_sc_range: assert property (@(posedge clk) disable iff (!arst_n)
		sc_vld |-> sc_ok)
		else $error("sine/cosine out of range");

	// a stall freezes the CORDIC-to-matrix boundary
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sc_vld) && $stable(sc))
		else $error("inner stage moved during stall");

endmodule
